@@ sv/tvl2e_pkg.sv @@
// ----------------------------------------------------------------------------
// tvl2e_pkg
// Shared widths, reset values, register codes and pipeline control types of
// the anisotropic TV-L2 primal energy block.
// ----------------------------------------------------------------------------
package tvl2e_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int CFG_DIM_W  = 13;
  localparam int WEIGHT_W   = 16;
  localparam int NOISY_W    = 8;
  localparam int EST_W      = 17;
  localparam int ENERGY_W   = 63;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // |difference| and |residual| both fit EST_W bits unsigned
  localparam int MAG_W    = EST_W;
  localparam int SMOOTH_W = MAG_W + 1;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int HALF_W   = MAG_W;
  localparam int PART_W   = WEIGHT_W + HALF_W;
  localparam int PROD_W   = WEIGHT_W + SQ_W;
  localparam int DATA_W   = PROD_W - 1;
  localparam int TERM_W   = DATA_W + 1;
  localparam int SUM_W    = ENERGY_W + 1;

  localparam logic [CFG_DIM_W-1:0] RST_IMAGE_WIDTH  = CFG_DIM_W'(640);
  localparam logic [CFG_DIM_W-1:0] RST_IMAGE_HEIGHT = CFG_DIM_W'(480);
  localparam logic [WEIGHT_W-1:0]  RST_DATA_WEIGHT  = WEIGHT_W'(256);

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_DATA_WEIGHT  = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic has_left;
    logic has_up;
  } pix_ctl_t;

endpackage

@@ sv/tvl2e_line_store.sv @@
// ----------------------------------------------------------------------------
// tvl2e_line_store
// One-row store of estimates; read-before-write at the same address, read data
// registered.
// ----------------------------------------------------------------------------
module tvl2e_line_store #(
  parameter int DEPTH = tvl2e_pkg::DEF_MAX_WIDTH,
  parameter int AW    = $clog2(tvl2e_pkg::DEF_MAX_WIDTH)
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [AW-1:0]                 addr,
  input  logic [tvl2e_pkg::EST_W-1:0]   wdata,
  output logic [tvl2e_pkg::EST_W-1:0]   rdata
);

  logic [tvl2e_pkg::EST_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      rdata     <= mem[addr];
      mem[addr] <= wdata;
    end
  end

endmodule

@@ sv/tvl2e_datapath.sv @@
// ----------------------------------------------------------------------------
// tvl2e_datapath
// Per-pixel energy term: smoothness differences plus lambda/2 times the
// squared data residual, in six registered stages.
// ----------------------------------------------------------------------------
module tvl2e_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 advance,
  input  tvl2e_pkg::pix_ctl_t                  in_ctl,
  input  logic [tvl2e_pkg::NOISY_W-1:0]        in_noisy,
  input  logic signed [tvl2e_pkg::EST_W-1:0]   in_est,
  input  logic signed [tvl2e_pkg::EST_W-1:0]   in_left,
  input  logic signed [tvl2e_pkg::EST_W-1:0]   above,
  input  logic [tvl2e_pkg::WEIGHT_W-1:0]       data_weight,
  output tvl2e_pkg::pix_ctl_t                  term_ctl,
  output logic [tvl2e_pkg::TERM_W-1:0]         term
);

  localparam int EW = tvl2e_pkg::EST_W;
  localparam int MW = tvl2e_pkg::MAG_W;

  tvl2e_pkg::pix_ctl_t c1, c2, c3, c4, c5;

  logic signed [EW-1:0]                  u1, left1;
  logic [tvl2e_pkg::NOISY_W-1:0]         f1;
  logic [tvl2e_pkg::SMOOTH_W-1:0]        smooth2, smooth3, smooth4, smooth5;
  logic [MW-1:0]                         absr2;
  logic [tvl2e_pkg::SQ_W-1:0]            sq3;
  logic [tvl2e_pkg::PART_W-1:0]          plo4, phi4;
  logic [tvl2e_pkg::DATA_W-1:0]          data5;

  logic signed [EW:0]                    d_left, d_up, resid;
  logic [MW-1:0]                         a_left, a_up, a_resid;
  logic [tvl2e_pkg::SMOOTH_W-1:0]        smooth_sum;
  logic [tvl2e_pkg::PROD_W-1:0]          prod;

  always_comb begin
    d_left  = (EW+1)'(u1) - (EW+1)'(left1);
    d_up    = (EW+1)'(u1) - (EW+1)'(above);
    resid   = $signed({2'b0, f1, 8'b0}) - (EW+1)'(u1);
    a_left  = d_left[EW] ? MW'(-d_left) : MW'(d_left);
    a_up    = d_up[EW] ? MW'(-d_up) : MW'(d_up);
    a_resid = resid[EW] ? MW'(-resid) : MW'(resid);
    smooth_sum = (c1.has_left ? tvl2e_pkg::SMOOTH_W'(a_left) : '0)
               + (c1.has_up ? tvl2e_pkg::SMOOTH_W'(a_up) : '0);
    prod = {phi4, {tvl2e_pkg::HALF_W{1'b0}}} + tvl2e_pkg::PROD_W'(plo4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
      c2 <= '0;
      c3 <= '0;
      c4 <= '0;
      c5 <= '0;
      term_ctl <= '0;
    end else if (advance) begin
      c1 <= in_ctl;
      c2 <= c1;
      c3 <= c2;
      c4 <= c3;
      c5 <= c4;
      term_ctl <= c5;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      u1      <= in_est;
      left1   <= in_left;
      f1      <= in_noisy;
      smooth2 <= smooth_sum;
      absr2   <= a_resid;
      sq3     <= absr2 * absr2;
      smooth3 <= smooth2;
      plo4    <= data_weight * sq3[tvl2e_pkg::HALF_W-1:0];
      phi4    <= data_weight * sq3[tvl2e_pkg::SQ_W-1:tvl2e_pkg::HALF_W];
      smooth4 <= smooth3;
      data5   <= prod[tvl2e_pkg::PROD_W-1:1];
      smooth5 <= smooth4;
      term    <= tvl2e_pkg::TERM_W'(data5)
               + tvl2e_pkg::TERM_W'({smooth5, 16'b0});
    end
  end

endmodule

@@ sv/tvl2e_accum.sv @@
// ----------------------------------------------------------------------------
// tvl2e_accum
// Saturating energy accumulator and output register; emits the image energy
// at the last pixel and restarts.
// ----------------------------------------------------------------------------
module tvl2e_accum (
  input  logic                              clk,
  input  logic                              rst,
  input  tvl2e_pkg::pix_ctl_t               term_ctl,
  input  logic [tvl2e_pkg::TERM_W-1:0]      term,
  output logic                              stall,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tvl2e_pkg::ENERGY_W-1:0]    out_energy,
  output logic                              out_overflowed
);

  logic [tvl2e_pkg::ENERGY_W-1:0] sum;
  logic                           flag;
  logic [tvl2e_pkg::SUM_W-1:0]    raw;
  logic                           ovf;
  logic [tvl2e_pkg::ENERGY_W-1:0] sum_sat;
  logic                           fire;

  always_comb begin
    raw     = tvl2e_pkg::SUM_W'(sum) + tvl2e_pkg::SUM_W'(term);
    ovf     = raw[tvl2e_pkg::SUM_W-1];
    sum_sat = ovf ? tvl2e_pkg::ENERGY_MAX : raw[tvl2e_pkg::ENERGY_W-1:0];
    stall   = term_ctl.valid && term_ctl.last && out_valid && !out_ready;
    fire    = term_ctl.valid && !stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum       <= '0;
      flag      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (fire) begin
        if (term_ctl.last) begin
          out_valid <= 1'b1;
          sum       <= '0;
          flag      <= 1'b0;
        end else begin
          sum  <= sum_sat;
          flag <= flag | ovf;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && term_ctl.last) begin
      out_energy     <= sum_sat;
      out_overflowed <= flag | ovf;
    end
  end

  a_flag_sticks_at_max: assert property (@(posedge clk) disable iff (rst)
    flag |-> sum == tvl2e_pkg::ENERGY_MAX)
    else $error("saturation flag set without a saturated sum");

  a_restart_after_emit: assert property (@(posedge clk) disable iff (rst)
    fire && term_ctl.last |=> sum == '0 && !flag)
    else $error("accumulator not cleared after image end");

endmodule

@@ sv/tv_l2_primal_energy.sv @@
// ----------------------------------------------------------------------------
// tv_l2_primal_energy
// Anisotropic TV-L2 primal energy over a raster-order pixel stream.
// ----------------------------------------------------------------------------
// One pixel item is taken per clock. Each item adds |u - left| and |u - above|
// (from a one-row line store of MAX_WIDTH entries, read and written at the
// accept edge) plus lambda/2 * (f*256 - u)^2 to a 63-bit saturating sum with
// 24 fraction bits. An image's energy, with overflowed set if the sum saturated,
// appears on the output once its last pixel has passed the datapath and the
// accumulator's output register. Input is held off only while one energy item
// waits to be taken and the next image's last pixel reaches the accumulator.
// Width and height of 0 act as 1, values above MAX_WIDTH / MAX_HEIGHT act as
// those maxima. Write registers only while no image is in progress.
// ----------------------------------------------------------------------------
module tv_l2_primal_energy #(
  parameter int MAX_WIDTH  = tvl2e_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = tvl2e_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tvl2e_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [tvl2e_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [tvl2e_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                pready,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [31:0]                         s_tdata,  // noisy_sample[7:0], estimate_sample[24:8]
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [63:0]                         m_tdata   // energy[62:0], overflowed[63]
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WDW = $clog2(MAX_WIDTH + 1);
  localparam int HDW = $clog2(MAX_HEIGHT + 1);
  localparam int WCW = (WDW > tvl2e_pkg::CFG_DIM_W) ? WDW : tvl2e_pkg::CFG_DIM_W;
  localparam int HCW = (HDW > tvl2e_pkg::CFG_DIM_W) ? HDW : tvl2e_pkg::CFG_DIM_W;
  localparam int EW  = tvl2e_pkg::EST_W;

  logic [tvl2e_pkg::CFG_DIM_W-1:0] image_width, image_height;
  logic [tvl2e_pkg::WEIGHT_W-1:0]  data_weight;
  tvl2e_pkg::reg_index_t           reg_sel;
  logic                            cfg_we;

  logic [CW-1:0]        col_cnt;
  logic [RW-1:0]        row_cnt;
  logic signed [EW-1:0] left_estimate;

  logic [WCW-1:0] w_eff, col_next;
  logic [HCW-1:0] h_eff, row_next;
  logic           row_end, img_end;

  logic                           accept, stall;
  logic [tvl2e_pkg::NOISY_W-1:0]  noisy_sample;
  logic signed [EW-1:0]           estimate_sample;
  logic signed [EW-1:0]           above;
  tvl2e_pkg::pix_ctl_t            in_ctl, term_ctl;
  logic [tvl2e_pkg::TERM_W-1:0]   term;
  logic [tvl2e_pkg::ENERGY_W-1:0] energy;
  logic                           overflowed;

  assign pready  = 1'b1;
  assign reg_sel = tvl2e_pkg::reg_index_t'(paddr[3:2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_sel)
      tvl2e_pkg::REG_IMAGE_WIDTH:  prdata = tvl2e_pkg::APB_DATA_W'(image_width);
      tvl2e_pkg::REG_IMAGE_HEIGHT: prdata = tvl2e_pkg::APB_DATA_W'(image_height);
      tvl2e_pkg::REG_DATA_WEIGHT:  prdata = tvl2e_pkg::APB_DATA_W'(data_weight);
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= tvl2e_pkg::RST_IMAGE_WIDTH;
      image_height <= tvl2e_pkg::RST_IMAGE_HEIGHT;
      data_weight  <= tvl2e_pkg::RST_DATA_WEIGHT;
    end else if (cfg_we) begin
      unique case (reg_sel)
        tvl2e_pkg::REG_IMAGE_WIDTH:  image_width  <= pwdata[tvl2e_pkg::CFG_DIM_W-1:0];
        tvl2e_pkg::REG_IMAGE_HEIGHT: image_height <= pwdata[tvl2e_pkg::CFG_DIM_W-1:0];
        tvl2e_pkg::REG_DATA_WEIGHT:  data_weight  <= pwdata[tvl2e_pkg::WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) begin
      w_eff = WCW'(1);
    end else if (WCW'(image_width) > WCW'(MAX_WIDTH)) begin
      w_eff = WCW'(MAX_WIDTH);
    end else begin
      w_eff = WCW'(image_width);
    end
    if (image_height == '0) begin
      h_eff = HCW'(1);
    end else if (HCW'(image_height) > HCW'(MAX_HEIGHT)) begin
      h_eff = HCW'(MAX_HEIGHT);
    end else begin
      h_eff = HCW'(image_height);
    end
    col_next = WCW'(col_cnt) + WCW'(1);
    row_next = HCW'(row_cnt) + HCW'(1);
    row_end  = col_next >= w_eff;
    img_end  = row_end && (row_next >= h_eff);
  end

  assign s_tready        = !stall;
  assign accept          = s_tvalid && s_tready;
  assign noisy_sample    = s_tdata[7:0];
  assign estimate_sample = s_tdata[24:8];

  always_comb begin
    in_ctl.valid    = accept;
    in_ctl.last     = img_end;
    in_ctl.has_left = col_cnt != '0;
    in_ctl.has_up   = row_cnt != '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt       <= '0;
      row_cnt       <= '0;
      left_estimate <= '0;
    end else if (accept) begin
      left_estimate <= estimate_sample;
      if (row_end) begin
        col_cnt <= '0;
        row_cnt <= img_end ? '0 : row_next[RW-1:0];
      end else begin
        col_cnt <= col_next[CW-1:0];
      end
    end
  end

  tvl2e_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_store (
    .clk   (clk),
    .en    (accept),
    .addr  (col_cnt),
    .wdata (estimate_sample),
    .rdata (above)
  );

  tvl2e_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .advance     (!stall),
    .in_ctl      (in_ctl),
    .in_noisy    (noisy_sample),
    .in_est      (estimate_sample),
    .in_left     (left_estimate),
    .above       (above),
    .data_weight (data_weight),
    .term_ctl    (term_ctl),
    .term        (term)
  );

  tvl2e_accum u_accum (
    .clk            (clk),
    .rst            (rst),
    .term_ctl       (term_ctl),
    .term           (term),
    .stall          (stall),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_energy     (energy),
    .out_overflowed (overflowed)
  );

  assign m_tdata = {overflowed, energy};

  a_hold_only_on_full_output: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input held off with output register empty");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    WCW'(col_cnt) < WCW'(MAX_WIDTH))
    else $error("column counter beyond line store");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    HCW'(row_cnt) < HCW'(MAX_HEIGHT))
    else $error("row counter beyond maximum height");

endmodule
